/* rtl/core/pba_pkg.sv */
// pba_pkg: shared constants, payload structs, control structs and sequencer
// states for the per-frame paged bump allocator
// no dependencies
package pba_pkg;

  localparam int FRAMES     = 2;
  localparam int MAX_PAGES  = 16;
  localparam int PAGE_BYTES = 64 * 1024;

  localparam int STAMP_W    = 32;
  localparam int SIZE_W     = 24;
  localparam int ALIGN_W    = 17;
  localparam int SLOT_OUT_W = 3;
  localparam int PAGE_OUT_W = 4;
  localparam int OFS_W      = 24;
  localparam int CAP_W      = 25;

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CUR_W  = $clog2(MAX_PAGES + 1);
  localparam int DEPTH  = FRAMES * MAX_PAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam bit FRAMES_POW2 = ((FRAMES & (FRAMES - 1)) == 0);

  typedef struct packed {
    logic [STAMP_W-1:0] frame_stamp;
    logic [SIZE_W-1:0]  req_size;
    logic [ALIGN_W-1:0] req_align;
  } pba_in_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic [PAGE_OUT_W-1:0] page_number;
    logic [OFS_W-1:0]      byte_offset;
    logic                  page_opened;
    logic [CAP_W-1:0]      opened_bytes;
  } pba_out_t;

  // page store command
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_cap_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CAP_W-1:0]  wr_cap;
    logic [CAP_W-1:0]  wr_fill;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_slot;
  } pba_pm_cmd_t;

  // remainder unit command
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [CNT_W-1:0]   nbits;
    logic [ALIGN_W-1:0] divisor;
  } pba_div_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_FRAME,
    ST_WALK,
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } pba_state_t;

endpackage

/* rtl/core/pba_div.sv */
// pba_div: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on pba_pkg
module pba_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pba_pkg::pba_div_cmd_t       cmd,
  output logic                        done,
  output logic [pba_pkg::ALIGN_W-1:0] rem
);
  import pba_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [ALIGN_W-1:0]   rem_r, rem_nxt;
  logic [ALIGN_W-1:0]   dvs_r, dvs_nxt;
  logic [ALIGN_W:0]     trial;

  // dividend is consumed msb first
  assign trial = {rem_r, dvd_r[DIV_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.nbits;
      dvd_nxt  = cmd.dividend;
      rem_nxt  = '0;
      dvs_nxt  = cmd.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ALIGN_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[ALIGN_W-1:0];
      end
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/pba_page_mem.sv */
// pba_page_mem: page capacity and fill store with registered read and
// per-page fill valid bits that a new frame clears for its slot at once
// depends on pba_pkg
module pba_page_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pba_pkg::pba_pm_cmd_t      cmd,
  output logic [pba_pkg::CAP_W-1:0] rd_cap,
  output logic [pba_pkg::CAP_W-1:0] rd_fill
);
  import pba_pkg::*;

  logic [CAP_W-1:0] cap_mem [DEPTH];
  logic [CAP_W-1:0] fill_mem [DEPTH];
  logic [DEPTH-1:0] fvalid_r, fvalid_nxt;
  logic [CAP_W-1:0] rd_cap_r;
  logic [CAP_W-1:0] rd_fill_r;
  logic             rd_vld_r;

  always_comb begin
    fvalid_nxt = fvalid_r;
    if (cmd.clr_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if ((i / MAX_PAGES) == int'(cmd.clr_slot)) begin
          fvalid_nxt[i] = 1'b0;
        end
      end
    end
    if (cmd.wr_en) begin
      fvalid_nxt[cmd.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
    end else begin
      fvalid_r <= fvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      fill_mem[cmd.wr_addr] <= cmd.wr_fill;
    end
    if (cmd.wr_cap_en) begin
      cap_mem[cmd.wr_addr] <= cmd.wr_cap;
    end
    if (cmd.rd_en) begin
      rd_cap_r  <= cap_mem[cmd.rd_addr];
      rd_fill_r <= fill_mem[cmd.rd_addr];
      rd_vld_r  <= fvalid_r[cmd.rd_addr];
    end
  end

  // a page not written since its frame began reads as empty
  assign rd_cap  = rd_cap_r;
  assign rd_fill = rd_vld_r ? rd_fill_r : '0;

endmodule

/* rtl/core/per_frame_paged_bump_allocator_top.sv */
// per_frame_paged_bump_allocator_top: request sequencer, per-slot state and
// result register; uses pba_pkg, pba_div and pba_page_mem
//
// Each request word carries a frame stamp, a size and an alignment, and gets
// exactly one result word. The stamp selects a frame slot (stamp modulo the
// frame count); a stamp new to that slot empties all of the slot's pages when
// the size is nonzero. Open pages are tried from the slot's cursor upward. Each
// page tried gets a lookup and a fit check, with a pass through the shared
// bit-serial remainder unit when the page already holds data. When no page
// fits, a new page of max(64 KiB, size) is opened, up to 16 pages per slot,
// and beyond that the request fails. The slot comes straight from the stamp
// with a power-of-two frame count and from the remainder unit otherwise.
// in_ready is high only between requests; a finished result waits in the
// output register without holding up the next request.
module per_frame_paged_bump_allocator_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pba_pkg::pba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pba_pkg::pba_out_t out_data
);
  import pba_pkg::*;

  pba_state_t         state_r, state_nxt;
  pba_in_t            req_r, req_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [ALIGN_W-1:0] rem_r, rem_nxt;
  pba_out_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  pba_out_t           out_data_r, out_data_nxt;

  logic [STAMP_W-1:0] stamp_r [FRAMES];
  logic [STAMP_W-1:0] stamp_nxt [FRAMES];
  logic [CUR_W-1:0]   cursor_r [FRAMES];
  logic [CUR_W-1:0]   cursor_nxt [FRAMES];
  logic [CUR_W-1:0]   open_r [FRAMES];
  logic [CUR_W-1:0]   open_nxt [FRAMES];

  pba_pm_cmd_t        pm_cmd;
  pba_div_cmd_t       div_cmd;
  logic [CAP_W-1:0]   pm_cap, pm_fill;
  logic               div_done;
  logic [ALIGN_W-1:0] div_rem;

  logic [CUR_W-1:0]   cur, opn;
  logic [ADDR_W-1:0]  cur_addr, open_addr;
  logic               walk_ok, slot_full, out_free;
  logic [CAP_W-1:0]   room, pad, ofs, new_fill, new_cap;
  logic               fits;

  pba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .done  (div_done),
    .rem   (div_rem)
  );

  pba_page_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (pm_cmd),
    .rd_cap  (pm_cap),
    .rd_fill (pm_fill)
  );

  assign cur       = cursor_r[slot_r];
  assign opn       = open_r[slot_r];
  assign cur_addr  = ADDR_W'(int'(slot_r) * MAX_PAGES + int'(cur[PAGE_W-1:0]));
  assign open_addr = ADDR_W'(int'(slot_r) * MAX_PAGES + int'(opn[PAGE_W-1:0]));
  assign walk_ok   = (cur < opn) && (cur < CUR_W'(MAX_PAGES));
  assign slot_full = (opn >= CUR_W'(MAX_PAGES));
  assign out_free  = !out_valid_r || out_ready;

  // fit check on the page just read, rem_r is fill modulo alignment
  assign room     = pm_cap - pm_fill;
  assign pad      = (rem_r == '0) ? '0 : CAP_W'(align_r - rem_r);
  assign fits     = (pad <= room) && (CAP_W'(req_r.req_size) <= room - pad);
  assign ofs      = pm_fill + pad;
  assign new_fill = ofs + CAP_W'(req_r.req_size);
  assign new_cap  = (CAP_W'(PAGE_BYTES) > CAP_W'(req_r.req_size)) ?
                    CAP_W'(PAGE_BYTES) : CAP_W'(req_r.req_size);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = FRAMES_POW2 ? ST_FRAME : ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (div_done) begin
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        state_nxt = (req_r.req_size == '0) ? ST_EMIT : ST_WALK;
      end
      ST_WALK: begin
        state_nxt = walk_ok ? ST_LOAD : ST_EMIT;
      end
      ST_LOAD: begin
        priority if (pm_fill > pm_cap) begin
          state_nxt = ST_WALK;
        end else if (pm_fill == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = fits ? ST_EMIT : ST_WALK;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, page store and remainder unit commands
  always_comb begin
    req_nxt    = req_r;
    align_nxt  = align_r;
    slot_nxt   = slot_r;
    rem_nxt    = rem_r;
    res_nxt    = res_r;
    stamp_nxt  = stamp_r;
    cursor_nxt = cursor_r;
    open_nxt   = open_r;
    pm_cmd     = '0;
    div_cmd    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          align_nxt = (in_data.req_align == '0) ? ALIGN_W'(1) : in_data.req_align;
          slot_nxt  = in_data.frame_stamp[SLOT_W-1:0] & SLOT_W'(FRAMES - 1);
          if (!FRAMES_POW2) begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = DIV_W'(in_data.frame_stamp);
            div_cmd.nbits    = CNT_W'(STAMP_W);
            div_cmd.divisor  = ALIGN_W'(FRAMES);
          end
        end
      end
      ST_SLOT: begin
        if (div_done) begin
          slot_nxt = SLOT_W'(div_rem);
        end
      end
      ST_FRAME: begin
        res_nxt            = '0;
        res_nxt.frame_slot = SLOT_OUT_W'(slot_r);
        if ((req_r.req_size != '0) && (stamp_r[slot_r] != req_r.frame_stamp)) begin
          stamp_nxt[slot_r]  = req_r.frame_stamp;
          cursor_nxt[slot_r] = '0;
          pm_cmd.clr_en      = 1'b1;
          pm_cmd.clr_slot    = slot_r;
        end
      end
      ST_WALK: begin
        if (walk_ok) begin
          pm_cmd.rd_en   = 1'b1;
          pm_cmd.rd_addr = cur_addr;
        end else if (!slot_full) begin
          // no open page fits, open the next one
          pm_cmd.wr_en        = 1'b1;
          pm_cmd.wr_cap_en    = 1'b1;
          pm_cmd.wr_addr      = open_addr;
          pm_cmd.wr_cap       = new_cap;
          pm_cmd.wr_fill      = CAP_W'(req_r.req_size);
          open_nxt[slot_r]    = opn + CUR_W'(1);
          cursor_nxt[slot_r]  = opn;
          res_nxt.granted      = 1'b1;
          res_nxt.page_number  = PAGE_OUT_W'(opn[PAGE_W-1:0]);
          res_nxt.byte_offset  = '0;
          res_nxt.page_opened  = 1'b1;
          res_nxt.opened_bytes = new_cap;
        end
      end
      ST_LOAD: begin
        priority if (pm_fill > pm_cap) begin
          cursor_nxt[slot_r] = cur + CUR_W'(1);
        end else if (pm_fill == '0) begin
          rem_nxt = '0;
        end else begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = DIV_W'(pm_fill) << (DIV_W - CAP_W);
          div_cmd.nbits    = CNT_W'(CAP_W);
          div_cmd.divisor  = align_r;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rem_nxt = div_rem;
        end
      end
      ST_CHECK: begin
        if (fits) begin
          pm_cmd.wr_en        = 1'b1;
          pm_cmd.wr_addr      = cur_addr;
          pm_cmd.wr_fill      = new_fill;
          res_nxt.granted     = 1'b1;
          res_nxt.page_number = PAGE_OUT_W'(cur[PAGE_W-1:0]);
          res_nxt.byte_offset = ofs[OFS_W-1:0];
        end else begin
          cursor_nxt[slot_r] = cur + CUR_W'(1);
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // result register, freed as soon as the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if ((state_r == ST_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        stamp_r[i]  <= '1;
        cursor_r[i] <= '0;
        open_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stamp_r     <= stamp_nxt;
      cursor_r    <= cursor_nxt;
      open_r      <= open_nxt;
    end
    req_r      <= req_nxt;
    align_r    <= align_nxt;
    slot_r     <= slot_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/tb_per_frame_paged_bump_allocator_top.sv */
`timescale 1ns / 1ps
// tb_per_frame_paged_bump_allocator_top: self-checking bench for the paged bump allocator
// predicts every result word with its own allocator model; needs pba_pkg and the allocator rtl
module tb_per_frame_paged_bump_allocator_top;
  import pba_pkg::*;

  localparam int N_RANDOM    = 525;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 600;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    pba_in_t req;
    bit      drain;
  } request_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pba_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pba_out_t out_data;

  request_t request_q[$];
  pba_out_t planned_grants[$];
  int       reqs_sent = 0;
  int       words_seen = 0;
  int       n_requests = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       drv_gap = 0;
  int       drv_calm = 0;
  int       mon_stall = 0;
  int       mon_calm = 0;

  // allocator model state
  logic [STAMP_W-1:0] last_stamp[FRAMES];
  int unsigned        walk_from[FRAMES];
  int unsigned        pages_used[FRAMES];
  int unsigned        page_cap[DEPTH];
  int unsigned        page_used[DEPTH];

  per_frame_paged_bump_allocator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic pba_out_t plan_allocation(pba_in_t req);
    pba_out_t    r;
    int unsigned slot, base, size, algn, p, cap, fill, room, pad, i;
    bit          placed;
    r = '0;
    slot = req.frame_stamp % FRAMES;
    r.frame_slot = SLOT_OUT_W'(slot);
    size = req.req_size;
    algn = req.req_align;
    if (size == 0) return r;
    if (algn == 0) algn = 1;
    base = slot * MAX_PAGES;
    // a new stamp empties the slot but keeps page capacities
    if (last_stamp[slot] != req.frame_stamp) begin
      last_stamp[slot] = req.frame_stamp;
      walk_from[slot] = 0;
      for (i = 0; i < MAX_PAGES; i++) page_used[base + i] = 0;
    end
    placed = 1'b0;
    while (!placed && walk_from[slot] < pages_used[slot] && walk_from[slot] < MAX_PAGES) begin
      p = walk_from[slot];
      cap = page_cap[base + p];
      fill = page_used[base + p];
      if (fill <= cap) begin
        room = cap - fill;
        pad = (fill % algn == 0) ? 0 : algn - fill % algn;
        if (pad <= room && size <= room - pad) begin
          placed = 1'b1;
          r.granted = 1'b1;
          r.page_number = PAGE_OUT_W'(p);
          r.byte_offset = OFS_W'(fill + pad);
          page_used[base + p] = fill + pad + size;
        end
      end
      if (!placed) walk_from[slot] = p + 1;
    end
    if (placed || pages_used[slot] >= MAX_PAGES) return r;
    p = pages_used[slot];
    cap = (size > PAGE_BYTES) ? size : PAGE_BYTES;
    page_cap[base + p] = cap;
    page_used[base + p] = size;
    pages_used[slot] = p + 1;
    walk_from[slot] = p;
    r.granted = 1'b1;
    r.page_number = PAGE_OUT_W'(p);
    r.page_opened = 1'b1;
    r.opened_bytes = CAP_W'(cap);
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_req(logic [STAMP_W-1:0] st, int unsigned sz, int unsigned al,
                                   bit drain);
    request_t e;
    e.req.frame_stamp = st;
    e.req.req_size = SIZE_W'(sz);
    e.req.req_align = ALIGN_W'(al);
    e.drain = drain;
    request_q.insert(request_q.size(), e);
    n_requests++;
  endfunction

  function automatic logic [STAMP_W-1:0] fresh_stamp(int unsigned slot);
    logic [STAMP_W-1:0] st;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) st = '0;
    else if (pick < 10) st = '1;
    else st = $urandom();
    return (st / FRAMES) * FRAMES + slot;
  endfunction

  // profile 0: small words, 1: mixed, 2: close to a page
  function automatic int unsigned rand_size(int profile);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 0;
    if (pick < 9) return $urandom_range(PAGE_BYTES + 1, 24'hFFFFFF);
    if (pick < 10) return 24'hFFFFFF;
    case (profile)
      0: return $urandom_range(1, 2048);
      1: return $urandom_range(1, 40000);
      default: return $urandom_range(20000, PAGE_BYTES);
    endcase
  endfunction

  function automatic int unsigned rand_align();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 1 << $urandom_range(0, 6);
    if (pick < 60) return 1 << $urandom_range(7, 16);
    if (pick < 75) return $urandom_range(1, 65536);
    if (pick < 85) return 1;
    if (pick < 90) return 0;
    if (pick < 95) return $urandom_range(0, 17'h1FFFF);
    return $urandom_range(3, 100);
  endfunction

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : driver
    bit fired;
    bit nxt_valid;
    fired = in_valid && in_ready;
    nxt_valid = in_valid && !fired;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (fired) begin
        planned_grants.insert(planned_grants.size(), plan_allocation(in_data));
        reqs_sent <= reqs_sent + 1;
        drv_gap = pick_gap(drv_calm);
      end
      if (!nxt_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && reqs_sent + int'(fired) != words_seen)) begin
          in_data <= request_q[0].req;
          request_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(posedge clk) begin : monitor
    pba_out_t want;
    bit       nxt_ready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        if (planned_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result word expected none, got %h", $time, out_data);
        end else begin
          want = planned_grants.pop_front();
          cmp_field("granted", want.granted, out_data.granted);
          cmp_field("frame_slot", want.frame_slot, out_data.frame_slot);
          cmp_field("page_number", want.page_number, out_data.page_number);
          cmp_field("byte_offset", want.byte_offset, out_data.byte_offset);
          cmp_field("page_opened", want.page_opened, out_data.page_opened);
          cmp_field("opened_bytes", want.opened_bytes, out_data.opened_bytes);
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if ($urandom_range(0, 99) < 20) mon_stall = pick_gap(mon_calm);
      end
    end
    out_ready <= nxt_ready;
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [STAMP_W-1:0] cur_stamp[FRAMES];
    int                 profile[FRAMES];
    int                 slot;
    int                 k;
    for (k = 0; k < FRAMES; k++) begin
      last_stamp[k] = '1;
      walk_from[k] = 0;
      pages_used[k] = 0;
      cur_stamp[k] = fresh_stamp(k);
      profile[k] = $urandom_range(0, 2);
    end
    for (k = 0; k < DEPTH; k++) begin
      page_cap[k] = 0;
      page_used[k] = 0;
    end

    // all-ones stamp on a fresh slot, zero size, zero and odd alignments
    push_req(32'hFFFF_FFFF, 1, 1, 1'b0);
    push_req(32'hFFFF_FFFF, 0, 1, 1'b0);
    push_req(32'hFFFF_FFFF, 5, 0, 1'b0);
    push_req(32'hFFFF_FFFF, 7, 3, 1'b0);
    push_req(32'hFFFF_FFFF, 100, 65536, 1'b0);
    push_req(32'hFFFF_FFFF, 24'hFFFFFF, 17'h1FFFF, 1'b0);
    push_req(32'h0000_0003, 1, 1, 1'b0);
    // fill every page of slot 0, then one more that must fail
    for (k = 0; k <= MAX_PAGES; k++) push_req(32'h0, PAGE_BYTES, 1, 1'b0);
    // new frame on the full slot reuses the old pages
    push_req(32'h2, 1, 65536, 1'b0);

    slot = 0;
    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 99) < 15) slot = $urandom_range(0, FRAMES - 1);
      if ($urandom_range(0, 99) < 6) begin
        cur_stamp[slot] = fresh_stamp(slot);
        profile[slot] = $urandom_range(0, 2);
      end
      push_req(cur_stamp[slot], rand_size(profile[slot]), rand_align(),
               k == 0 || k == 200 || k == 400);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (words_seen != n_requests);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (planned_grants.size() != 0) begin
      mismatches += planned_grants.size();
      $display("%0t: %0d result words never arrived", $time, planned_grants.size());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
